@@ rtl/lcts_pkg.sv @@
`timescale 1ns / 1ps

package lcts_pkg;

  // sizing of the window and of the sensor reading
  localparam int WINDOW_MAX  = 16;
  localparam int SAMPLE_BITS = 10;

  // fixed field widths
  localparam int W_BITS     = 20;
  localparam int OFF_BITS   = 11;
  localparam int SCALE_BITS = 16;
  localparam int WS_BITS    = 5;
  localparam int THR_BITS   = 19;
  localparam int FRAC_BITS  = 8;
  localparam int OFF_MAX    = 1023;

  // derived widths
  localparam int SLOT_BITS = $clog2(WINDOW_MAX);
  localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS  = W_BITS + SLOT_BITS;
  localparam int DIFF_BITS = ((SAMPLE_BITS + 1 > OFF_BITS) ? SAMPLE_BITS + 1 : OFF_BITS) + 1;
  localparam int SH_BITS   = DIFF_BITS + SCALE_BITS - FRAC_BITS;

  // weight limits
  localparam int W_MAX = 524287;
  localparam int W_MIN = -524288;

  // stream payload widths
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((W_BITS + 1 + OFF_BITS + 7) / 8) * 8;
  localparam int CFG_DATA_BITS = THR_BITS;

  // register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_ZERO_OFFSET      = 2'd0;
  localparam cfg_idx_t REG_SCALE_FACTOR     = 2'd1;
  localparam cfg_idx_t REG_WINDOW_SIZE      = 2'd2;
  localparam cfg_idx_t REG_DETECT_THRESHOLD = 2'd3;

  // register reset values
  localparam logic [SCALE_BITS-1:0] SCALE_RST  = SCALE_BITS'(256);
  localparam logic [WS_BITS-1:0]    WINDOW_RST = WS_BITS'(10);
  localparam logic [THR_BITS-1:0]   THR_RST    = THR_BITS'(50);

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ rtl/lcts_mul.sv @@
`timescale 1ns / 1ps

module lcts_mul
  import lcts_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [DIFF_BITS-1:0] diff,
  input  logic [SCALE_BITS-1:0]       scale,
  output unit_stat_t                  stat,
  output logic signed [W_BITS-1:0]    weight
);

  localparam int HI_BITS   = DIFF_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + SCALE_BITS;
  localparam int CNT_W     = $clog2(SCALE_BITS);
  localparam logic signed [SH_BITS-1:0] SH_MAX = SH_BITS'(W_MAX);
  localparam logic signed [SH_BITS-1:0] SH_MIN = SH_BITS'(W_MIN);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_SAT} mul_state_t;

  mul_state_t                  state_r;
  logic [CNT_W-1:0]            cnt_r;
  logic signed [HI_BITS-1:0]   hi_r;
  logic [SCALE_BITS-1:0]       lo_r;
  logic signed [DIFF_BITS-1:0] mcand_r;
  logic signed [W_BITS-1:0]    weight_r;
  logic                        done_r;

  logic signed [HI_BITS-1:0]   hi_sum;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [SH_BITS-1:0]   shifted;
  logic signed [W_BITS-1:0]    sat_w;

  // one multiplier bit per cycle, low bit first
  always_comb begin
    hi_sum = lo_r[0] ? (hi_r + {mcand_r[DIFF_BITS-1], mcand_r}) : hi_r;
  end

  // product shifted right by the fraction bits, then clamped
  always_comb begin
    prod    = $signed({hi_r[DIFF_BITS-1:0], lo_r});
    shifted = prod[PROD_BITS-1:FRAC_BITS];
    if (shifted > SH_MAX) begin
      sat_w = W_BITS'(W_MAX);
    end else if (shifted < SH_MIN) begin
      sat_w = W_BITS'(W_MIN);
    end else begin
      sat_w = shifted[W_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == M_SAT);
      case (state_r)
        M_IDLE: begin
          if (start) begin
            hi_r    <= '0;
            lo_r    <= scale;
            mcand_r <= diff;
            cnt_r   <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          hi_r  <= {hi_sum[HI_BITS-1], hi_sum[HI_BITS-1:1]};
          lo_r  <= {hi_sum[0], lo_r[SCALE_BITS-1:1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SCALE_BITS - 1)) begin
            state_r <= M_SAT;
          end
        end
        M_SAT: begin
          weight_r <= sat_w;
          state_r  <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != M_IDLE);
  assign stat.done = done_r;
  assign weight    = weight_r;

endmodule

@@ rtl/lcts_div.sv @@
`timescale 1ns / 1ps

module lcts_div
  import lcts_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SUM_BITS-1:0] dividend,
  input  logic [CNT_BITS-1:0]        divisor,
  output unit_stat_t                 stat,
  output logic signed [W_BITS-1:0]   quotient
);

  localparam int CNT_W = $clog2(SUM_BITS);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} div_state_t;

  div_state_t               state_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     neg_r;
  logic [SUM_BITS-1:0]      dvd_r;
  logic [CNT_BITS-1:0]      rem_r;
  logic [CNT_BITS-1:0]      dvs_r;
  logic signed [W_BITS-1:0] quot_r;
  logic                     done_r;

  logic [CNT_BITS:0]        trial;
  logic                     q_bit;
  logic [CNT_BITS:0]        trial_sub;
  logic [SUM_BITS-1:0]      mag_q;

  // restoring step: one quotient bit per cycle
  always_comb begin
    trial     = {rem_r, dvd_r[SUM_BITS-1]};
    q_bit     = (trial >= {1'b0, dvs_r});
    trial_sub = trial - {1'b0, dvs_r};
    mag_q     = neg_r ? (~dvd_r + 1'b1) : dvd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == D_FIX);
      case (state_r)
        D_IDLE: begin
          if (start) begin
            neg_r   <= dividend[SUM_BITS-1];
            dvd_r   <= dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
            dvs_r   <= divisor;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= q_bit ? trial_sub[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
          dvd_r <= {dvd_r[SUM_BITS-2:0], q_bit};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SUM_BITS - 1)) begin
            state_r <= D_FIX;
          end
        end
        D_FIX: begin
          // truncation toward zero: sign goes back on the magnitude
          quot_r  <= mag_q[W_BITS-1:0];
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != D_IDLE);
  assign stat.done = done_r;
  assign quotient  = quot_r;

endmodule

@@ rtl/load_cell_tare_scale_average.sv @@
`timescale 1ns / 1ps
// Sequence: an accepted sample passes through the bit-serial multiplier (16 steps plus start
//   and clamp), the window update and the bit-serial divider (24 quotient bits plus start and
//   sign fix) before out_tvalid rises; a tare goes straight to the result register.
// Flow: one transaction at a time, so a new sample or tare is taken only once the last one
//   has left; a held result stalls the input.
// Reset: synchronous active-low rst_n loads the register defaults and empties the window.
module load_cell_tare_scale_average
  import lcts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // [9:0] raw_sample
  input  logic                     in_tuser,   // [0] req_type
  // result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [19:0] avg_weight, [20] object_present,
                                               // [31:21] offset_now
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  cfg_idx_t                 cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUB, S_ADD, S_DIV, S_DONE} state_t;

  state_t                      state_r;

  // configuration registers
  logic [SCALE_BITS-1:0]       scale_factor_r;
  logic [WS_BITS-1:0]          window_size_r;
  logic [THR_BITS-1:0]         detect_threshold_r;

  // block state
  logic signed [OFF_BITS-1:0]  live_offset_r;
  logic [SLOT_BITS-1:0]        write_slot_r;
  logic [CNT_BITS-1:0]         held_count_r;
  logic signed [SUM_BITS-1:0]  running_sum_r;
  logic signed [W_BITS-1:0]    win_mem [WINDOW_MAX];
  logic signed [W_BITS-1:0]    old_r;

  // per-transaction working registers
  logic signed [DIFF_BITS-1:0] diff_r;
  logic [SLOT_BITS-1:0]        slot_r;
  logic                        mul_start_r;
  logic                        div_start_r;
  logic signed [W_BITS-1:0]    res_avg_r;
  logic                        res_present_r;
  logic                        out_valid_r;
  logic [OUT_DATA_BITS-1:0]    out_data_r;

  // unit interfaces
  unit_stat_t                  mul_stat;
  unit_stat_t                  div_stat;
  logic signed [W_BITS-1:0]    mul_w;
  logic signed [W_BITS-1:0]    div_q;

  // combinational helpers
  logic [SAMPLE_BITS-1:0]      raw;
  logic [CNT_BITS-1:0]         eff_n;
  logic [SLOT_BITS-1:0]        slot_use;
  logic [CNT_BITS-1:0]         slot_p1;
  logic [SLOT_BITS-1:0]        slot_nxt;
  logic                        win_full;
  logic signed [DIFF_BITS-1:0] raw_ext;
  logic signed [DIFF_BITS-1:0] off_ext;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [OFF_BITS-1:0]  tare_off;
  logic signed [SUM_BITS-1:0]  old_ext;
  logic signed [SUM_BITS-1:0]  w_ext;
  logic                        present;
  logic                        in_acc;
  logic                        cfg_acc;

  assign raw     = in_tdata[SAMPLE_BITS-1:0];
  assign in_acc  = in_tvalid && in_tready;
  assign cfg_acc = cfg_valid && cfg_ready;

  // effective window length, clamped to 1..WINDOW_MAX
  always_comb begin
    if (window_size_r == '0) begin
      eff_n = CNT_BITS'(1);
    end else if (int'(window_size_r) > WINDOW_MAX) begin
      eff_n = CNT_BITS'(WINDOW_MAX);
    end else begin
      eff_n = CNT_BITS'(window_size_r);
    end
  end

  // slot handling and window fill
  always_comb begin
    slot_use = (int'(write_slot_r) >= int'(eff_n)) ? '0 : write_slot_r;
    slot_p1  = CNT_BITS'(slot_r) + 1'b1;
    slot_nxt = (slot_p1 >= eff_n) ? '0 : slot_p1[SLOT_BITS-1:0];
    win_full = (held_count_r >= eff_n);
  end

  // offset removal and tare value
  always_comb begin
    raw_ext  = $signed({{(DIFF_BITS - SAMPLE_BITS){1'b0}}, raw});
    off_ext  = {{(DIFF_BITS - OFF_BITS){live_offset_r[OFF_BITS-1]}}, live_offset_r};
    diff     = raw_ext - off_ext;
    tare_off = (int'(raw) > OFF_MAX) ? OFF_BITS'(OFF_MAX) : OFF_BITS'(raw);
  end

  // sign extension into the running sum, threshold compare
  always_comb begin
    old_ext = {{(SUM_BITS - W_BITS){old_r[W_BITS-1]}}, old_r};
    w_ext   = {{(SUM_BITS - W_BITS){mul_w[W_BITS-1]}}, mul_w};
    present = (div_q > $signed({1'b0, detect_threshold_r}));
  end

  // window store: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (state_r == S_ADD) begin
      win_mem[slot_r] <= mul_w;
    end
    old_r <= win_mem[slot_r];
  end

  lcts_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start_r),
    .diff   (diff_r),
    .scale  (scale_factor_r),
    .stat   (mul_stat),
    .weight (mul_w)
  );

  lcts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (running_sum_r),
    .divisor  (held_count_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // sequencer, window bookkeeping, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      scale_factor_r     <= SCALE_RST;
      window_size_r      <= WINDOW_RST;
      detect_threshold_r <= THR_RST;
      live_offset_r      <= '0;
      write_slot_r       <= '0;
      held_count_r       <= '0;
      running_sum_r      <= '0;
      mul_start_r        <= 1'b0;
      div_start_r        <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      mul_start_r <= in_acc && !in_tuser;
      div_start_r <= (state_r == S_ADD);

      // result register: load when free or being taken, clear when taken
      if ((state_r == S_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= OUT_DATA_BITS'({live_offset_r, res_present_r, res_avg_r});
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser) begin
              live_offset_r <= tare_off;
              res_avg_r     <= '0;
              res_present_r <= 1'b0;
              state_r       <= S_DONE;
            end else begin
              diff_r  <= diff;
              slot_r  <= slot_use;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_stat.done) begin
            state_r <= S_SUB;
          end
        end
        S_SUB: begin
          // oldest entry leaves the sum once the window is full
          if (win_full) begin
            running_sum_r <= running_sum_r - old_ext;
          end
          state_r <= S_ADD;
        end
        S_ADD: begin
          running_sum_r <= running_sum_r + w_ext;
          if (!win_full) begin
            held_count_r <= held_count_r + 1'b1;
          end
          write_slot_r <= slot_nxt;
          state_r      <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            res_avg_r     <= div_q;
            res_present_r <= present;
            state_r       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // register writes arrive only while the block is idle
      if (cfg_acc) begin
        case (cfg_index)
          REG_ZERO_OFFSET: begin
            live_offset_r <= cfg_data[OFF_BITS-1:0];
          end
          REG_SCALE_FACTOR: begin
            scale_factor_r <= cfg_data[SCALE_BITS-1:0];
          end
          REG_WINDOW_SIZE: begin
            window_size_r <= cfg_data[WS_BITS-1:0];
            write_slot_r  <= '0;
            held_count_r  <= '0;
            running_sum_r <= '0;
          end
          REG_DETECT_THRESHOLD: begin
            detect_threshold_r <= cfg_data[THR_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // a pending register write goes ahead of a new transaction
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // the two serial units never run at the same time
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  // a new transaction is only taken with both units idle
  a_ready_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!mul_stat.busy && !div_stat.busy))
    else $error("input ready while a serial unit is busy");

  // the fill count never passes the window depth
  a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(held_count_r) <= WINDOW_MAX)
    else $error("held count beyond window depth");

  // divider start only follows the window update
  a_div_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> $past(state_r == S_ADD))
    else $error("divider started outside window update");
`endif

endmodule
